FILE: design/s2x_pkg.sv
// ----------------------------------------------------------------------------
// Scale2x upscaler package
// Shared widths, register indexes and the types passed between the blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package s2x_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 32;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int PB_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 2'd2;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    // neighbors of one source pixel: above, left, center, right, below
    typedef struct packed {
        pixel_t b;
        pixel_t d;
        pixel_t e;
        pixel_t f;
        pixel_t h;
    } nbr_t;

    typedef struct packed {
        pixel_t tl;
        pixel_t tr;
        pixel_t bl;
        pixel_t br;
    } quad_t;

    // sliding window around the current column
    typedef struct packed {
        pixel_t up_left;   // previous row, column x-1
        pixel_t up_mid;    // previous row, column x
        pixel_t up_right;  // previous row, column x+1
        pixel_t up_far;    // two rows up, column x
        pixel_t left1;     // current row, column x-1
        pixel_t left2;     // current row, column x-2
    } win_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last_col;
        logic             last_row;
    } pos_t;

    typedef struct packed {
        quad_t            pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             run_last;
        logic             frame_end;
    } result_t;

endpackage

`default_nettype wire

FILE: design/s2x_rule.sv
// ----------------------------------------------------------------------------
// Scale2x block rule
// Builds the 2x2 output block of one source pixel from its four neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module s2x_rule (
    input  s2x_pkg::nbr_t  nbr,
    output s2x_pkg::quad_t quad
);
    import s2x_pkg::*;

    always_comb
    begin
        quad.tl = (nbr.d == nbr.b && nbr.b != nbr.f && nbr.d != nbr.h) ? nbr.d : nbr.e;
        quad.tr = (nbr.b == nbr.f && nbr.b != nbr.d && nbr.f != nbr.h) ? nbr.f : nbr.e;
        quad.bl = (nbr.d == nbr.h && nbr.d != nbr.b && nbr.h != nbr.f) ? nbr.d : nbr.e;
        quad.br = (nbr.h == nbr.f && nbr.d != nbr.h && nbr.b != nbr.f) ? nbr.f : nbr.e;
    end

endmodule

`default_nettype wire

FILE: design/s2x_window.sv
// ----------------------------------------------------------------------------
// Scale2x line window
// Two line banks in one RAM, raster cursors and the neighbor window around
// the current column. Reloads the window from the RAM after reset and after
// every configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

module s2x_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [s2x_pkg::COL_W-1:0] wlast,
    input  logic [s2x_pkg::ROW_W-1:0] hlast,
    input  logic                      accept,
    input  s2x_pkg::pixel_t           pixel,
    output logic                      ready,
    output s2x_pkg::win_t             win,
    output s2x_pkg::pos_t             pos
);
    import s2x_pkg::*;

    localparam int AW    = COL_W + 1;
    localparam int DEPTH = 2 * MAX_WIDTH;

    typedef enum logic [3:0] {
        ST_FILL0 = 4'b0001,
        ST_FILL1 = 4'b0010,
        ST_FILL2 = 4'b0100,
        ST_RUN   = 4'b1000
    } fill_state_t;

    fill_state_t      state_reg;
    fill_state_t      state_next;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             bank_reg;
    logic             pf_mem_reg;
    logic             cb_mem_reg;

    pixel_t           line_mem [DEPTH];
    pixel_t           rdp_data_reg;
    pixel_t           rdc_data_reg;

    pixel_t           pd_reg;
    pixel_t           pe_reg;
    pixel_t           pf_byp_reg;
    pixel_t           cb_byp_reg;
    pixel_t           lp1_reg;
    pixel_t           lp2_reg;
    pixel_t           r0_reg;
    pixel_t           r1_reg;
    pixel_t           top0_reg;

    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             last_col;
    logic             last_row;
    logic [COL_W-1:0] xm1;
    logic [COL_W-1:0] xm2;
    logic [COL_W-1:0] xp1;
    logic [COL_W-1:0] xp2;
    logic [COL_W-1:0] p_col;
    logic [COL_W-1:0] c_col;
    logic             p_re;
    logic             c_re;
    logic [AW-1:0]    p_addr;
    logic [AW-1:0]    c_addr;
    logic [AW-1:0]    w_addr;
    pixel_t           pf;
    pixel_t           cb;
    pixel_t           first0;
    pixel_t           first1;

    // clamp cursors to the frame in case the size shrank mid-frame
    always_comb
    begin
        x        = (col_reg < wlast) ? col_reg : wlast;
        y        = (row_reg < hlast) ? row_reg : hlast;
        last_col = (x == wlast);
        last_row = (y == hlast);
        xm1      = (x == '0) ? '0 : x - COL_W'(1);
        xm2      = (x < COL_W'(2)) ? '0 : x - COL_W'(2);
        xp1      = last_col ? x : x + COL_W'(1);
        xp2      = (last_col || xp1 == wlast) ? wlast : xp1 + COL_W'(1);
        pf       = pf_mem_reg ? rdp_data_reg : pf_byp_reg;
        cb       = cb_mem_reg ? rdc_data_reg : cb_byp_reg;
        // first pixels of the row being finished, seen by the next row
        first0   = (x == '0) ? pixel : r0_reg;
        first1   = (x <= COL_W'(1)) ? pixel : r1_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        p_re       = 1'b0;
        c_re       = 1'b0;
        p_col      = xm1;
        c_col      = xm1;
        case (state_reg)
            ST_FILL0:
            begin
                p_re       = 1'b1;
                c_re       = 1'b1;
                state_next = ST_FILL1;
            end
            ST_FILL1:
            begin
                p_re       = 1'b1;
                c_re       = 1'b1;
                p_col      = x;
                c_col      = xm2;
                state_next = ST_FILL2;
            end
            ST_FILL2:
            begin
                p_re       = 1'b1;
                c_re       = 1'b1;
                p_col      = xp1;
                c_col      = x;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // prefetch what the next column needs
                if (accept && !last_col)
                begin
                    p_re  = 1'b1;
                    c_re  = 1'b1;
                    p_col = xp2;
                    c_col = xp1;
                end
            end
            default:
            begin
                state_next = ST_FILL0;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_FILL0;
        end
    end

    assign p_addr = {~bank_reg, p_col};
    assign c_addr = {bank_reg, c_col};
    assign w_addr = {bank_reg, x};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[w_addr] <= pixel;
        end
        if (p_re)
        begin
            rdp_data_reg <= line_mem[p_addr];
        end
        if (c_re)
        begin
            rdc_data_reg <= line_mem[c_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_FILL0;
            col_reg    <= '0;
            row_reg    <= '0;
            bank_reg   <= 1'b0;
            pf_mem_reg <= 1'b0;
            cb_mem_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FILL2)
            begin
                pf_mem_reg <= 1'b1;
                cb_mem_reg <= 1'b1;
            end
            if (accept)
            begin
                if (last_col)
                begin
                    col_reg    <= '0;
                    bank_reg   <= ~bank_reg;
                    row_reg    <= last_row ? '0 : y + ROW_W'(1);
                    pf_mem_reg <= 1'b0;
                    cb_mem_reg <= 1'b0;
                end
                else
                begin
                    col_reg    <= xp1;
                    row_reg    <= y;
                    pf_mem_reg <= 1'b1;
                    cb_mem_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FILL1)
        begin
            pd_reg  <= rdp_data_reg;
            lp1_reg <= rdc_data_reg;
        end
        if (state_reg == ST_FILL2)
        begin
            pe_reg  <= rdp_data_reg;
            lp2_reg <= rdc_data_reg;
        end
        if (accept)
        begin
            lp1_reg <= pixel;
            lp2_reg <= lp1_reg;
            if (x == '0)
            begin
                r0_reg <= pixel;
            end
            if (x == COL_W'(1))
            begin
                r1_reg <= pixel;
            end
            if (last_col)
            begin
                // swap banks: the finished row becomes the row above
                pd_reg     <= first0;
                pe_reg     <= first0;
                pf_byp_reg <= first1;
                cb_byp_reg <= top0_reg;
                top0_reg   <= first0;
            end
            else
            begin
                pd_reg <= pe_reg;
                pe_reg <= pf;
            end
        end
    end

    assign ready = (state_reg == ST_RUN);

    always_comb
    begin
        win.up_left  = pd_reg;
        win.up_mid   = pe_reg;
        win.up_right = pf;
        win.up_far   = cb;
        win.left1    = lp1_reg;
        win.left2    = lp2_reg;
        pos.col      = x;
        pos.row      = y;
        pos.last_col = last_col;
        pos.last_row = last_row;
    end

endmodule

`default_nettype wire

FILE: design/scale2x_pixel_upscaler_unit.sv
// ----------------------------------------------------------------------------
// Scale2x pixel upscaler
// Streams source pixels in raster order and returns 2x2 Scale2x blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / pixel_in) takes one source pixel per
//   transfer, raster order. Output channel (out_valid / out_stall) returns
//   one 2x2 block per transfer with its source column and row.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) sets
//   frame width, frame height and bytes per pixel; write it between frames
//   or while the stream is idle.
//   The block of row y is built and queued when the pixel below it is taken.
//   Rows before the last run at one pixel per cycle while out_stall is low.
//   On the last row each pixel also releases the block to its left, so there
//   the output port limits the rate; the final pixel gives up to three blocks.
//   Results wait in a four-entry queue, so input keeps flowing while results
//   sit stalled, until the queue cannot hold the next pixel's blocks.
//   After reset and after every configuration write the neighbor window is
//   reloaded from the line RAM through states FILL0, FILL1 and FILL2, with
//   in_stall high. Reset returns to the frame origin with 320x240 at four
//   bytes per pixel; the line RAM itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module scale2x_pixel_upscaler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  s2x_pkg::pixel_t                pixel_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output s2x_pkg::pixel_t                top_left,
    output s2x_pkg::pixel_t                top_right,
    output s2x_pkg::pixel_t                bottom_left,
    output s2x_pkg::pixel_t                bottom_right,
    output logic [s2x_pkg::COL_W-1:0]      src_col,
    output logic [s2x_pkg::ROW_W-1:0]      src_row,
    output logic                           run_last,
    output logic                           frame_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [s2x_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [s2x_pkg::CFG_DATA_W-1:0] cfg_data
);
    import s2x_pkg::*;

    localparam int                   RES_DEPTH = 4;
    localparam int                   PTR_W     = $clog2(RES_DEPTH);
    localparam int                   CNT_W     = PTR_W + 1;
    localparam logic [CNT_W-1:0]     RES_FULL  = CNT_W'(RES_DEPTH);

    function automatic pixel_t pix_mask(input logic [PB_W-1:0] nbytes);
        pixel_t m;
        case (nbytes)
            3'd1:    m = pixel_t'(32'h0000_00FF);
            3'd2:    m = pixel_t'(32'h0000_FFFF);
            3'd3:    m = pixel_t'(32'h00FF_FFFF);
            default: m = '1;
        endcase
        return m;
    endfunction

    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [PB_W-1:0]  bytes_reg;

    logic             cfg_we;
    logic [COL_W-1:0] wlast;
    logic [ROW_W-1:0] hlast;
    pixel_t           pixel;
    logic             in_acc;
    logic             win_ready;
    win_t             win;
    pos_t             pos;

    nbr_t             nbr_a;
    nbr_t             nbr_l;
    nbr_t             nbr_f;
    quad_t            quad_a;
    quad_t            quad_l;
    quad_t            quad_f;

    logic             first_row;
    logic             second_row;
    logic             first_col;
    logic             has_a;
    logic             has_l;
    logic             has_f;
    logic [1:0]       n_res;
    result_t          res_a;
    result_t          res_l;
    result_t          res_f;
    result_t          slot [3];

    result_t          res_buf_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_xfer;
    result_t          head;

    // configuration
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FW_W'(320);
            height_reg <= FH_W'(240);
            bytes_reg  <= PB_W'(4);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                REG_PIXEL_BYTES:  bytes_reg  <= cfg_data[PB_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            wlast = '0;
        end
        else if (width_reg > FW_W'(MAX_WIDTH))
        begin
            wlast = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast = COL_W'(width_reg - FW_W'(1));
        end
        hlast = (height_reg == '0) ? '0 : ROW_W'(height_reg - FH_W'(1));
    end

    assign pixel = pixel_in & pix_mask(bytes_reg);

    s2x_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_we (cfg_we),
        .wlast  (wlast),
        .hlast  (hlast),
        .accept (in_acc),
        .pixel  (pixel),
        .ready  (win_ready),
        .win    (win),
        .pos    (pos)
    );

    // neighbor sets for the block above, the block to the left on the last
    // row, and the final block of the frame
    always_comb
    begin
        first_row  = (pos.row == '0);
        second_row = (pos.row == ROW_W'(1));
        first_col  = (pos.col == '0);

        nbr_a.b = second_row ? win.up_mid : win.up_far;
        nbr_a.d = win.up_left;
        nbr_a.e = win.up_mid;
        nbr_a.f = win.up_right;
        nbr_a.h = pixel;

        nbr_l.b = first_row ? win.left1 : win.up_left;
        nbr_l.d = (pos.col >= COL_W'(2)) ? win.left2 : win.left1;
        nbr_l.e = win.left1;
        nbr_l.f = pixel;
        nbr_l.h = win.left1;

        nbr_f.b = first_row ? pixel : win.up_mid;
        nbr_f.d = first_col ? pixel : win.left1;
        nbr_f.e = pixel;
        nbr_f.f = pixel;
        nbr_f.h = pixel;
    end

    s2x_rule u_rule_a (.nbr(nbr_a), .quad(quad_a));
    s2x_rule u_rule_l (.nbr(nbr_l), .quad(quad_l));
    s2x_rule u_rule_f (.nbr(nbr_f), .quad(quad_f));

    always_comb
    begin
        has_a = !first_row;
        has_l = pos.last_row && !first_col;
        has_f = pos.last_row && pos.last_col;
        n_res = {1'b0, has_a} + {1'b0, has_l} + {1'b0, has_f};

        res_a.pix       = quad_a;
        res_a.col       = pos.col;
        res_a.row       = pos.row - ROW_W'(1);
        res_a.run_last  = !(has_l || has_f);
        res_a.frame_end = 1'b0;

        res_l.pix       = quad_l;
        res_l.col       = pos.col - COL_W'(1);
        res_l.row       = pos.row;
        res_l.run_last  = !has_f;
        res_l.frame_end = 1'b0;

        res_f.pix       = quad_f;
        res_f.col       = pos.col;
        res_f.row       = pos.row;
        res_f.run_last  = 1'b1;
        res_f.frame_end = 1'b1;

        // pack the present results in order
        slot[0] = has_a ? res_a : (has_l ? res_l : res_f);
        slot[1] = (has_a && has_l) ? res_l : res_f;
        slot[2] = res_f;
    end

    // hold input on reload, or when the queue cannot take this pixel's blocks
    assign in_stall = !win_ready || cfg_we || ((cnt_reg + CNT_W'(n_res)) > RES_FULL);
    assign in_acc   = in_valid && !in_stall;

    assign out_valid = (cnt_reg != '0);
    assign out_xfer  = out_valid && !out_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc)
        begin
            cnt_next = cnt_next + CNT_W'(n_res);
        end
        if (out_xfer)
        begin
            cnt_next = cnt_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_acc)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (in_acc && (k < int'(n_res)))
            begin
                res_buf_reg[wr_ptr_reg + PTR_W'(k)] <= slot[k];
            end
        end
    end

    assign head         = res_buf_reg[rd_ptr_reg];
    assign top_left     = head.pix.tl;
    assign top_right    = head.pix.tr;
    assign bottom_left  = head.pix.bl;
    assign bottom_right = head.pix.br;
    assign src_col      = head.col;
    assign src_row      = head.row;
    assign run_last     = head.run_last;
    assign frame_end    = head.frame_end;

    // queue occupancy follows pushes and pops
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> cnt_reg == $past(cnt_reg) + CNT_W'($past(n_res)) - CNT_W'($past(out_xfer)))
        else $error("result queue count out of step");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RES_FULL)
        else $error("result queue overflow");

    a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_acc)
        else $error("pixel taken before window reload");

    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> run_last)
        else $error("frame end block not last of its pixel");

endmodule

`default_nettype wire

FILE: bench/scale2x_pixel_upscaler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scale2x pixel upscaler testbench
// Streams raster frames of many sizes and depths through the upscaler. A
// software line-store model predicts every 2x2 block; each output transfer
// is checked against it in order. Both sides idle at random, bar the final phase.
// ----------------------------------------------------------------------------

import s2x_pkg::*;

class scale2x_predictor;
    int unsigned frame_w;
    int unsigned frame_h;
    int unsigned depth_bytes;
    pixel_t      line_mem [2][MAX_WIDTH];
    int unsigned col_pos;
    int unsigned row_pos;
    bit          bank_sel;
    result_t     pending_blocks [$];
    int          errors;

    function new();
        frame_w     = 320;
        frame_h     = 240;
        depth_bytes = 4;
        col_pos     = 0;
        row_pos     = 0;
        bank_sel    = 1'b0;
        errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FRAME_WIDTH:  frame_w = val[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_h = val[FH_W-1:0];
            REG_PIXEL_BYTES:  depth_bytes = val[PB_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned eff_width();
        if (frame_w == 0)
            return 1;
        return (frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w;
    endfunction

    function int unsigned eff_height();
        return (frame_h == 0) ? 1 : frame_h;
    endfunction

    function pixel_t depth_mask();
        if (depth_bytes >= 1 && depth_bytes <= 3)
            return (32'h1 << (depth_bytes * 8)) - 32'h1;
        return '1;
    endfunction

    function bit busy();
        return pending_blocks.size() != 0;
    endfunction

    function bit at_origin();
        return col_pos == 0 && row_pos == 0;
    endfunction

    function quad_t scale_rule(pixel_t b, pixel_t d, pixel_t e, pixel_t f, pixel_t h);
        quad_t q;
        q.tl = (d == b && b != f && d != h) ? d : e;
        q.tr = (b == f && b != d && f != h) ? f : e;
        q.bl = (d == h && d != b && h != f) ? d : e;
        q.br = (h == f && d != h && b != f) ? f : e;
        return q;
    endfunction

    function result_t make_block(pixel_t b, pixel_t d, pixel_t e, pixel_t f, pixel_t h,
                                 int unsigned x, int unsigned y, bit fend);
        result_t r;
        r.pix       = scale_rule(b, d, e, f, h);
        r.col       = x[COL_W-1:0];
        r.row       = y[ROW_W-1:0];
        r.run_last  = 1'b0;
        r.frame_end = fend;
        return r;
    endfunction

    // Advance the line stores by one accepted source pixel.
    function void note_pixel(pixel_t raw);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        pixel_t      p;
        pixel_t      e;
        pixel_t      d;
        pixel_t      f;
        pixel_t      b;
        bit          last_col;
        bit          last_row;
        result_t     made [3];
        int          n;
        w = eff_width();
        h = eff_height();
        p = raw & depth_mask();
        // a cursor past a shrunk frame acts as the last column or row
        x = (col_pos < w - 1) ? col_pos : w - 1;
        y = (row_pos < h - 1) ? row_pos : h - 1;
        last_col = (x == w - 1);
        last_row = (y == h - 1);
        n = 0;
        if (y >= 1) begin
            e = line_mem[~bank_sel][x];
            d = line_mem[~bank_sel][(x == 0) ? 0 : x - 1];
            f = line_mem[~bank_sel][last_col ? x : x + 1];
            b = (y == 1) ? e : line_mem[bank_sel][x];
            made[n] = make_block(b, d, e, f, p, x, y - 1, 1'b0);
            n++;
        end
        line_mem[bank_sel][x] = p;
        // last row: the block to the left is complete now
        if (last_row && x >= 1) begin
            e = line_mem[bank_sel][x - 1];
            d = line_mem[bank_sel][(x >= 2) ? x - 2 : 0];
            b = (y == 0) ? e : line_mem[~bank_sel][x - 1];
            made[n] = make_block(b, d, e, p, e, x - 1, y, 1'b0);
            n++;
        end
        if (last_row && last_col) begin
            d = (x == 0) ? p : line_mem[bank_sel][x - 1];
            b = (y == 0) ? p : line_mem[~bank_sel][x];
            made[n] = make_block(b, d, p, p, p, x, y, 1'b1);
            n++;
        end
        if (n > 0)
            made[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_blocks.push_back(made[i]);
        if (last_col) begin
            col_pos  = 0;
            bank_sel = ~bank_sel;
            row_pos  = last_row ? 0 : y + 1;
        end
        else begin
            col_pos = x + 1;
            row_pos = y;
        end
    endfunction

    function void cmp(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endfunction

    function void check_block(result_t got);
        result_t want;
        if (pending_blocks.size() == 0) begin
            $display("%0t: unexpected block: expected none, actual col %0d row %0d",
                     $time, got.col, got.row);
            errors++;
            return;
        end
        want = pending_blocks.pop_front();
        cmp("top_left",     want.pix.tl,    got.pix.tl);
        cmp("top_right",    want.pix.tr,    got.pix.tr);
        cmp("bottom_left",  want.pix.bl,    got.pix.bl);
        cmp("bottom_right", want.pix.br,    got.pix.br);
        cmp("src_col",      want.col,       got.col);
        cmp("src_row",      want.row,       got.row);
        cmp("run_last",     want.run_last,  got.run_last);
        cmp("frame_end",    want.frame_end, got.frame_end);
    endfunction
endclass

module scale2x_pixel_upscaler_unit_tb;

    localparam int QUIET_LIMIT = 5000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    pixel_t                pixel_in  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    pixel_t                top_left;
    pixel_t                top_right;
    pixel_t                bottom_left;
    pixel_t                bottom_right;
    logic [COL_W-1:0]      src_col;
    logic [ROW_W-1:0]      src_row;
    logic                  run_last;
    logic                  frame_end;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    scale2x_predictor board = new();

    int     send_idle_pct  = 32;
    int     recv_stall_pct = 53;
    int     items_sent     = 0;
    int     quiet_cycles   = 0;
    pixel_t palette [3];

    // masked to 24 bits: corners zero, A above and left of E, C right and below
    pixel_t rule_pattern [9] = '{
        32'hFF000000, 32'h0100AAAA, 32'h02000000,
        32'h0300AAAA, 32'h04555555, 32'h05CCCCCC,
        32'h06000000, 32'h07CCCCCC, 32'h08000000
    };

    scale2x_pixel_upscaler_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_in     (pixel_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .top_left     (top_left),
        .top_right    (top_right),
        .bottom_left  (bottom_left),
        .bottom_right (bottom_right),
        .src_col      (src_col),
        .src_row      (src_row),
        .run_last     (run_last),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : block_monitor
        result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.pix.tl    = top_left;
            got.pix.tr    = top_right;
            got.pix.bl    = bottom_left;
            got.pix.br    = bottom_right;
            got.col       = src_col;
            got.row       = src_row;
            got.run_last  = run_last;
            got.frame_end = frame_end;
            board.check_block(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic pixel_t next_pixel();
        pixel_t m;
        m = board.depth_mask();
        if ($urandom_range(0, 99) < 15)
            return $urandom;
        return ($urandom & ~m) | (palette[$urandom_range(0, 2)] & m);
    endfunction

    task automatic new_palette();
        foreach (palette[i])
            palette[i] = $urandom;
    endtask

    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_pixel(p);
        items_sent++;
    endtask

    // Hold input until every predicted block has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.busy());
    endtask

    task automatic settle();
        drain();
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned pb);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_PIXEL_BYTES};
        val = '{CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(pb)};
        settle();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            board.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic feed(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 23) == 0)
                drain();
            send_pixel(next_pixel());
        end
    endtask

    task automatic feed_to_origin();
        do begin
            if ($urandom_range(0, 23) == 0)
                drain();
            send_pixel(next_pixel());
        end while (!board.at_origin());
    endtask

    task automatic random_frame();
        int unsigned w;
        int unsigned h;
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        h = $urandom_range(1, 5);
        configure(w, h, $urandom_range(0, 7));
        new_palette();
        // cut the frame short and shrink it mid-stream
        if ($urandom_range(0, 4) == 0) begin
            feed($urandom_range(0, w * h - 1));
            configure($urandom_range(1, w), $urandom_range(1, h), $urandom_range(0, 7));
        end
        feed_to_origin();
    endtask

    initial
    begin
        int goal;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: a few pixels of the first row, then shrink both sizes
        new_palette();
        feed(8);
        configure(3, 2, 4);
        feed_to_origin();

        configure(1, 1, 4);
        send_pixel('1);
        // zero width, height and depth act as one, one and four
        configure(0, 0, 0);
        send_pixel('0);
        configure(4, 1, 1);
        feed_to_origin();
        configure(1, 4, 2);
        feed_to_origin();
        configure(3, 3, 3);
        foreach (rule_pattern[i])
            send_pixel(rule_pattern[i]);

        // tallest frame, then shrink so the cursor lies past the new last row
        configure(2, 4095, 4);
        feed(10);
        configure(2, 3, 5);
        feed_to_origin();

        // width above the line store: a few pixels, then shrink to end the row
        configure(2047, 1, 7);
        feed(6);
        configure(3, 1, 4);
        feed_to_origin();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 32; recv_stall_pct = 53; end
                1: begin send_idle_pct = 53; recv_stall_pct = 32; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            goal = items_sent + 15;
            while (items_sent < goal)
                random_frame();
        end

        settle();
        repeat (16) @(posedge clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
design/s2x_pkg.sv
design/s2x_rule.sv
design/s2x_window.sv
design/scale2x_pixel_upscaler_unit.sv
bench/scale2x_pixel_upscaler_unit_tb.sv
